/* design/lrld_pkg.sv */
// Shared types and constants of the lightmap run-length decoder.
`default_nettype none

package lrld_pkg;

  localparam logic MODE_WORD   = 1'b0;
  localparam logic MODE_SHADOW = 1'b1;

  localparam logic REG_FORMAT_MODE = 1'b0;
  localparam logic REG_PIXEL_LIMIT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_LIMIT = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  localparam logic [2:0]  PHASE_COUNT  = 3'd4;
  localparam logic [2:0]  PHASE_LAST   = 3'd3;
  localparam logic [31:0] TAG_VAL_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] SHADE_BLACK  = 32'h0000_0000;
  localparam logic [31:0] SHADE_WHITE  = 32'hFFFF_FFFF;

  // A run candidate from the front, before the limit check.
  typedef struct packed {
    logic [31:0] pix;
    logic [7:0]  cnt;
    logic        cand;
    logic        last;
    logic        trunc;
  } cand_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        run_valid;
    logic        record_end;
    logic [1:0]  record_status;
  } result_t;

endpackage

`default_nettype wire

/* design/lrld_fifo.sv */
// Small register FIFO used between the decoder stages and at the output.
`default_nettype none

module lrld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/lrld_front.sv */
// Front stage: gathers tags, tracks the shadow fill and forms run candidates.
`default_nettype none

module lrld_front (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       record_last,
  input  wire logic       format_mode,
  output logic            mid_push,
  output lrld_pkg::cand_t mid_item
);

  logic [2:0]  byte_phase;
  logic [31:0] tag_word;
  logic        fill_toggle;
  logic [2:0]  byte_phase_next;
  logic [31:0] tag_word_next;
  logic        fill_toggle_next;
  logic [31:0] tag_ins;

  always_comb begin
    byte_phase_next  = byte_phase;
    tag_word_next    = tag_word;
    fill_toggle_next = fill_toggle;
    tag_ins          = ((byte_phase == 3'd0) ? 32'd0 : tag_word)
                     | (32'(data_byte) << {byte_phase[1:0], 3'b000});
    mid_item         = '0;
    mid_item.last    = record_last;
    if (format_mode == lrld_pkg::MODE_SHADOW) begin
      mid_item.cand    = 1'b1;
      mid_item.cnt     = data_byte;
      mid_item.pix     = fill_toggle ? lrld_pkg::SHADE_WHITE : lrld_pkg::SHADE_BLACK;
      fill_toggle_next = ~fill_toggle;
    end else if (byte_phase != lrld_pkg::PHASE_COUNT) begin
      tag_word_next   = tag_ins;
      byte_phase_next = byte_phase + 3'd1;
      if (byte_phase == lrld_pkg::PHASE_LAST) begin
        if (tag_ins[31]) begin
          // Continuation tag: the next byte carries the repeat count.
          tag_word_next = tag_ins & lrld_pkg::TAG_VAL_MASK;
        end else begin
          byte_phase_next = 3'd0;
          mid_item.cand   = 1'b1;
          mid_item.cnt    = 8'd1;
          mid_item.pix    = tag_ins;
        end
      end
    end else begin
      byte_phase_next = 3'd0;
      mid_item.cand   = 1'b1;
      mid_item.cnt    = data_byte;
      mid_item.pix    = tag_word;
    end
    mid_item.trunc = (byte_phase_next != 3'd0);
  end

  assign mid_push = accept && (mid_item.cand || record_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= '0;
      tag_word    <= '0;
      fill_toggle <= 1'b0;
    end else if (accept) begin
      if (record_last) begin
        byte_phase  <= '0;
        tag_word    <= '0;
        fill_toggle <= 1'b0;
      end else begin
        byte_phase  <= byte_phase_next;
        tag_word    <= tag_word_next;
        fill_toggle <= fill_toggle_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/lrld_back.sv */
// Back stage: checks the pixel limit and builds result beats.
`default_nettype none

module lrld_back #(
  parameter int LIMIT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [LIMIT_WIDTH-1:0] pixel_limit,
  input  wire logic                   mid_empty,
  input  wire lrld_pkg::cand_t        mid_item,
  output logic                        mid_pop,
  input  wire logic                   out_full,
  output logic                        out_push,
  output lrld_pkg::result_t           out_item
);

  logic [LIMIT_WIDTH:0] pixel_total;
  logic [LIMIT_WIDTH:0] total_sum;
  logic                 error_code;
  logic                 over;
  logic                 admit;
  logic                 emit;
  logic                 err_now;

  assign total_sum = pixel_total + (LIMIT_WIDTH + 1)'(mid_item.cnt);
  assign over      = total_sum > {1'b0, pixel_limit};
  assign admit     = !error_code && mid_item.cand && !over;
  assign err_now   = error_code || (mid_item.cand && over);
  assign emit      = admit && (mid_item.cnt != 8'd0);

  assign mid_pop  = !mid_empty && (!out_full || !(emit || mid_item.last));
  assign out_push = mid_pop && (emit || mid_item.last);

  always_comb begin
    out_item               = '0;
    out_item.run_valid     = emit;
    out_item.pixel_value   = emit ? mid_item.pix : 32'd0;
    out_item.run_length    = emit ? mid_item.cnt : 8'd0;
    out_item.record_end    = mid_item.last;
    out_item.record_status = lrld_pkg::STATUS_OK;
    if (mid_item.last) begin
      if (err_now) begin
        out_item.record_status = lrld_pkg::STATUS_LIMIT;
      end else if (mid_item.trunc) begin
        out_item.record_status = lrld_pkg::STATUS_TRUNC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= '0;
      error_code  <= 1'b0;
    end else if (mid_pop) begin
      if (mid_item.last) begin
        pixel_total <= '0;
        error_code  <= 1'b0;
      end else begin
        error_code <= err_now;
        if (admit) begin
          pixel_total <= total_sum;
        end
      end
    end
  end

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_push && !out_item.record_end |-> out_item.record_status == lrld_pkg::STATUS_OK)
    else $error("status set on a beat that does not end a record");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_push && out_item.run_valid |-> out_item.run_length != 8'd0)
    else $error("valid run with zero length");

  a_record_clears: assert property (@(posedge clk) disable iff (rst)
    mid_pop && mid_item.last |=> pixel_total == '0 && !error_code)
    else $error("record state not cleared at record end");

endmodule

`default_nettype wire

/* design/lightmap_run_length_decoder_top.sv */
// Top level of the lightmap run-length decoder.
//
// Input channel: one compressed byte per beat (data_byte, record_last),
// taken at a clock edge with push high and full low. Result channel: run
// descriptors (pixel_value, run_length, run_valid, record_end,
// record_status) shown while empty is low and taken with pop.
// Each input beat gives zero or one result beat: one when a nonzero run
// completes within the pixel limit or when the byte ends its record.
// The front stage decodes tags and shadow toggles as the byte is accepted
// and writes a candidate into a two-entry queue. The back stage pops it,
// checks the running pixel total against pixel_limit (one add and compare)
// and writes the result into a two-entry output queue. A result is
// written into the middle queue as its byte is taken and into the output
// queue when the back stage pops it; one byte is taken per cycle for as
// long as results are drained. When pop is held low the output queue
// fills, then the middle queue, and full rises; no beat is lost. Reset
// clears both queues and all record state and sets format_mode to 0 and
// pixel_limit to 1024. The user must write registers over the APB-style
// port only while the block is idle; the block does not enforce this.
`default_nettype none

module lightmap_run_length_decoder_top #(
  parameter int LIMIT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input.
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        record_last,
  // Run output.
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      pixel_value,
  output logic [7:0]       run_length,
  output logic             run_valid,
  output logic             record_end,
  output logic [1:0]       record_status,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                   format_mode;
  logic [LIMIT_WIDTH-1:0] pixel_limit;
  logic                   reg_write;

  logic                   accept;
  logic                   mid_push;
  logic                   mid_full;
  logic                   mid_empty;
  logic                   mid_pop;
  lrld_pkg::cand_t        mid_in;
  lrld_pkg::cand_t        mid_out;
  logic                   out_push;
  logic                   out_full;
  lrld_pkg::result_t      out_in;
  lrld_pkg::result_t      out_out;

  // Register file. Register 0 sits at byte address 0 and register 1 at 4.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= lrld_pkg::MODE_WORD;
      pixel_limit <= LIMIT_WIDTH'(16'd1024);
    end else if (reg_write) begin
      if (paddr[2] == lrld_pkg::REG_FORMAT_MODE) begin
        format_mode <= pwdata[0];
      end else begin
        pixel_limit <= LIMIT_WIDTH'(pwdata[15:0]);
      end
    end
  end

  assign prdata = (paddr[2] == lrld_pkg::REG_FORMAT_MODE) ? 32'(format_mode)
                                                          : 32'(pixel_limit);

  // The input side is ready whenever the middle queue has room.
  assign full   = mid_full;
  assign accept = push && !mid_full;

  lrld_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .record_last (record_last),
    .format_mode (format_mode),
    .mid_push    (mid_push),
    .mid_item    (mid_in)
  );

  lrld_fifo #(
    .WIDTH ($bits(lrld_pkg::cand_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  lrld_back #(
    .LIMIT_WIDTH (LIMIT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pixel_limit (pixel_limit),
    .mid_empty   (mid_empty),
    .mid_item    (mid_out),
    .mid_pop     (mid_pop),
    .out_full    (out_full),
    .out_push    (out_push),
    .out_item    (out_in)
  );

  lrld_fifo #(
    .WIDTH ($bits(lrld_pkg::result_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_out),
    .empty (empty)
  );

  assign pixel_value   = out_out.pixel_value;
  assign run_length    = out_out.run_length;
  assign run_valid     = out_out.run_valid;
  assign record_end    = out_out.record_end;
  assign record_status = out_out.record_status;

endmodule

`default_nettype wire

/* tb/lightmap_run_length_decoder_top_tb.sv */
// Self-checking testbench for the lightmap run-length decoder top level.
module lightmap_run_length_decoder_top_tb;

  // Register addresses: register i sits at byte address 4*i.
  localparam logic [2:0] ADDR_FORMAT_MODE = {lrld_pkg::REG_FORMAT_MODE, 2'b00};
  localparam logic [2:0] ADDR_PIXEL_LIMIT = {lrld_pkg::REG_PIXEL_LIMIT, 2'b00};

  // Bytes offered per random phase, and the number of random phases.
  localparam int PHASE_BYTES = 150;
  localparam int PHASES      = 12;
  // A byte that gives no result may still sit in the middle queue after it is
  // taken; leave a wide margin.
  localparam int IDLE_TAIL   = 8;
  // Length of the long receiver hold-off that backs the block up.
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        record_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] pixel_value;
  logic [7:0]  run_length;
  logic        run_valid;
  logic        record_end;
  logic [1:0]  record_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lightmap_run_length_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .record_last   (record_last),
    .empty         (empty),
    .pop           (pop),
    .pixel_value   (pixel_value),
    .run_length    (run_length),
    .run_valid     (run_valid),
    .record_end    (record_end),
    .record_status (record_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bytes waiting to be offered; the front one is on the ports while push is high.
  byte_beat_t        byte_backlog[$];
  // Run descriptors the decoder owes us, oldest first.
  lrld_pkg::result_t expected_runs[$];

  // Shadow copy of the decoder's registers and record state.
  logic        cur_mode;
  logic [15:0] cur_limit;
  logic [2:0]  tag_phase;
  logic [31:0] tag_acc;
  logic [16:0] run_pixels;
  logic        shade_sel;
  logic        overflowed;

  // Idling is switched off for the closing phases.
  bit idle_on = 1'b1;
  // The stimulus asks for long hold-offs; the receiver serves them.
  int holds_asked = 0;
  int holds_done  = 0;

  int errors         = 0;
  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int runs_checked   = 0;
  int records_done   = 0;
  int limit_records  = 0;
  int trunc_records  = 0;
  int full_cycles    = 0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Adds the run to the record's pixel total unless that would pass the limit;
  // passing it marks the record as overflowed.
  function automatic logic run_fits(input logic [7:0] cnt);
    logic [16:0] sum;
    sum = run_pixels + 17'(cnt);
    if (sum > 17'(cur_limit)) begin
      overflowed = 1'b1;
      return 1'b0;
    end
    run_pixels = sum;
    return 1'b1;
  endfunction

  // Decodes one accepted byte and records the result it owes, if any.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    lrld_pkg::result_t r;
    logic              have;
    logic [31:0]       pix;
    logic [7:0]        cnt;
    have = 1'b0;
    pix  = '0;
    cnt  = '0;
    if (!overflowed) begin
      if (cur_mode == lrld_pkg::MODE_SHADOW) begin
        // Every byte is a count; the pixel flips between black and white.
        cnt = b;
        pix = shade_sel ? lrld_pkg::SHADE_WHITE : lrld_pkg::SHADE_BLACK;
        shade_sel = ~shade_sel;
        have = run_fits(cnt);
      end else if (tag_phase < lrld_pkg::PHASE_COUNT) begin
        // Gather the tag little-endian; a set top bit means a count byte follows.
        if (tag_phase == '0) tag_acc = '0;
        tag_acc = tag_acc | (32'(b) << (8 * tag_phase));
        tag_phase = tag_phase + 3'd1;
        if (tag_phase == lrld_pkg::PHASE_COUNT) begin
          if (tag_acc[31]) begin
            tag_acc = tag_acc & lrld_pkg::TAG_VAL_MASK;
          end else begin
            tag_phase = '0;
            cnt = 8'd1;
            pix = tag_acc;
            have = run_fits(cnt);
          end
        end
      end else begin
        tag_phase = '0;
        cnt = b;
        pix = tag_acc;
        have = run_fits(cnt);
      end
    end
    // A zero-length run is never reported as a run.
    if (cnt == 8'd0) have = 1'b0;
    if (have || last) begin
      r.pixel_value   = have ? pix : '0;
      r.run_length    = have ? cnt : '0;
      r.run_valid     = have;
      r.record_end    = last;
      r.record_status = lrld_pkg::STATUS_OK;
      if (last) begin
        records_done++;
        if (overflowed) begin
          r.record_status = lrld_pkg::STATUS_LIMIT;
          limit_records++;
        end else if (tag_phase != '0) begin
          r.record_status = lrld_pkg::STATUS_TRUNC;
          trunc_records++;
        end
        tag_phase  = '0;
        tag_acc    = '0;
        run_pixels = '0;
        shade_sel  = 1'b0;
        overflowed = 1'b0;
      end
      expected_runs.push_back(r);
    end
  endtask

  // Accepted byte beats and register accesses update the prediction at the
  // rising edge on which the block takes them.
  always @(posedge clk) begin : byte_taker
    logic [31:0] want_rd;
    if (rst) begin
      cur_mode   <= lrld_pkg::MODE_WORD;
      cur_limit  <= 16'd1024;
      tag_phase  <= '0;
      tag_acc    <= '0;
      run_pixels <= '0;
      shade_sel  <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      if (full) full_cycles++;
      if (push && !full) begin
        decode_byte(data_byte, record_last);
        void'(byte_backlog.pop_front());
        bytes_taken++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_FORMAT_MODE) cur_mode = pwdata[0];
          else if (paddr == ADDR_PIXEL_LIMIT) cur_limit = pwdata[15:0];
        end else begin
          want_rd = (paddr == ADDR_FORMAT_MODE) ? {31'h0, cur_mode} : {16'h0, cur_limit};
          if (prdata !== want_rd)
            flag_error($sformatf("register read at %0d: expected %h, got %h",
                                 paddr, want_rd, prdata));
        end
      end
    end
  end

  // Sender: offers the front of the backlog, with random idle bursts.
  int send_gap = 0;
  always @(negedge clk) begin : byte_driver
    logic go;
    go = 1'b0;
    if (!rst) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (byte_backlog.size() != 0) begin
        if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(0, 16);
        else go = 1'b1;
      end
    end
    push <= go;
    if (go) begin
      data_byte   <= byte_backlog[0].data;
      record_last <= byte_backlog[0].last;
    end
  end

  // Receiver: pops results, with random stall bursts and, on request, one
  // long hold-off so that both queues in the block fill and full rises.
  int sink_gap  = 0;
  int hold_left = 0;
  always @(negedge clk) begin : run_sink
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < holds_asked) begin
        hold_left = LONG_HOLD - 1;
        holds_done++;
      end else if (sink_gap > 0) begin
        sink_gap--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 16);
      end else begin
        take = 1'b1;
      end
    end
    pop <= take;
  end

  // Checker: every result beat taken is compared with the oldest expectation.
  always @(posedge clk) begin : run_checker
    lrld_pkg::result_t want;
    if (!rst && pop && !empty) begin
      runs_checked++;
      if (expected_runs.size() == 0) begin
        flag_error($sformatf("unexpected result: pix=%h len=%0d valid=%b end=%b status=%0d",
                             pixel_value, run_length, run_valid, record_end, record_status));
      end else begin
        want = expected_runs.pop_front();
        if (pixel_value !== want.pixel_value || run_length !== want.run_length ||
            run_valid !== want.run_valid || record_end !== want.record_end ||
            record_status !== want.record_status)
          flag_error($sformatf({"result mismatch: expected pix=%h len=%0d valid=%b end=%b ",
                                "status=%0d, got pix=%h len=%0d valid=%b end=%b status=%0d"},
                               want.pixel_value, want.run_length, want.run_valid,
                               want.record_end, want.record_status, pixel_value,
                               run_length, run_valid, record_end, record_status));
      end
    end
  end

  // Register accesses: a setup phase, then an access phase.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] addr);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    byte_beat_t beat;
    beat.data = b;
    beat.last = last;
    byte_backlog.push_back(beat);
    bytes_queued++;
  endtask

  // The block is idle once all bytes are in and all results are out; a byte
  // with no result may still be in flight, so an idle tail follows.
  task automatic wait_idle();
    while (byte_backlog.size() != 0 || expected_runs.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Repeat counts lean toward the ends: zero and 255 show up often.
  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 200));
    endcase
  endfunction

  // One word-mode record; a cut record ends inside a tag or before its count.
  task automatic queue_word_record(input int runs, input bit cut);
    logic [7:0]  bytes[$];
    logic [31:0] tag;
    int          keep;
    for (int r = 0; r < runs; r++) begin
      tag = $urandom();
      tag[31] = 1'($urandom_range(0, 1));
      for (int k = 0; k < 4; k++) bytes.push_back(tag[8*k +: 8]);
      if (tag[31]) bytes.push_back(pick_count());
    end
    if (cut) begin
      tag = $urandom();
      tag[31] = 1'b1;
      keep = $urandom_range(1, 4);
      for (int k = 0; k < keep; k++) bytes.push_back(tag[8*k +: 8]);
    end
    foreach (bytes[i]) queue_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic queue_shadow_record(input int runs);
    for (int r = 0; r < runs; r++) queue_byte(pick_count(), r == runs - 1);
  endtask

  initial begin : stimulus
    logic        phase_mode;
    logic [15:0] phase_limit;
    int          start;
    int          sel;
    int          noise_len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values of both registers.
    reg_read(ADDR_FORMAT_MODE);
    reg_read(ADDR_PIXEL_LIMIT);

    // Word mode: a plain tag, a tag with the largest count, a tag with a zero
    // count, a counted tag whose count byte ends the record, then records that
    // end inside a tag and while the count byte is still awaited.
    queue_byte(8'h78, 1'b0); queue_byte(8'h56, 1'b0);
    queue_byte(8'h34, 1'b0); queue_byte(8'h12, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h02, 1'b0); queue_byte(8'h03, 1'b0);
    queue_byte(8'h84, 1'b0); queue_byte(8'h03, 1'b1);
    queue_byte(8'h11, 1'b0); queue_byte(8'h22, 1'b1);
    queue_byte(8'h05, 1'b0); queue_byte(8'h05, 1'b0); queue_byte(8'h05, 1'b0);
    queue_byte(8'hD5, 1'b1);
    wait_idle();

    // Shadow mode with a zero limit: a zero run toggles the fill, the next run
    // overflows, and the rest of the record is dropped.
    reg_write(ADDR_FORMAT_MODE, {31'h0, lrld_pkg::MODE_SHADOW});
    reg_write(ADDR_PIXEL_LIMIT, 32'h0);
    queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'h07, 1'b1);
    wait_idle();

    // Random phases, each with its own mode and limit. Phase boundaries are
    // also the points where the sender waits for every result to come back.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          phase_mode = lrld_pkg::MODE_WORD;   phase_limit = 16'd1024;
        end
        1: begin
          phase_mode = lrld_pkg::MODE_SHADOW; phase_limit = 16'd1024;
        end
        2: begin
          phase_mode = lrld_pkg::MODE_WORD;   phase_limit = 16'hFFFF;
        end
        3: begin
          phase_mode = lrld_pkg::MODE_SHADOW; phase_limit = 16'hFFFF;
        end
        4: begin
          phase_mode = lrld_pkg::MODE_WORD;   phase_limit = 16'd0;
        end
        5: begin
          phase_mode = lrld_pkg::MODE_SHADOW; phase_limit = 16'($urandom_range(1, 40));
        end
        6: begin
          phase_mode = lrld_pkg::MODE_WORD;   phase_limit = 16'($urandom_range(1, 200));
        end
        7: begin
          phase_mode = lrld_pkg::MODE_SHADOW; phase_limit = 16'($urandom());
        end
        default: begin
          phase_mode = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 4))
            0:       phase_limit = 16'd0;
            1:       phase_limit = 16'($urandom_range(1, 300));
            2:       phase_limit = 16'd1024;
            3:       phase_limit = 16'hFFFF;
            default: phase_limit = 16'($urandom());
          endcase
        end
      endcase
      idle_on = (ph < PHASES - 2);

      // Upper bits of the written data carry junk; the block keeps only the
      // register's own width.
      reg_write(ADDR_FORMAT_MODE, {31'($urandom()), phase_mode});
      reg_write(ADDR_PIXEL_LIMIT, {16'($urandom()), phase_limit});
      reg_read(ADDR_FORMAT_MODE);
      reg_read(ADDR_PIXEL_LIMIT);

      // Shadow mode with the top limit gives a result for every byte with a nonzero
      // count or a record end: hold the receiver off so the block fills and pushes back on the sender.
      if (ph == 3) holds_asked++;

      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) begin
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          // Well-formed records for the current mode, sometimes cut short.
          if (phase_mode == lrld_pkg::MODE_WORD)
            queue_word_record($urandom_range(1, 6), $urandom_range(0, 5) == 0);
          else
            queue_shadow_record($urandom_range(1, 12));
        end else if (sel == 8) begin
          // A record shaped for the other mode.
          if (phase_mode == lrld_pkg::MODE_WORD) queue_shadow_record($urandom_range(1, 8));
          else queue_word_record($urandom_range(1, 3), 1'b0);
        end else begin
          // Noise: random bytes with random record ends.
          noise_len = $urandom_range(1, 8);
          for (int k = 0; k < noise_len; k++)
            queue_byte(8'($urandom()), $urandom_range(0, 2) == 0);
        end
      end
      // Sometimes leave a record open, so the next phase's settings take
      // over in the middle of it.
      if ($urandom_range(0, 1) == 1) begin
        noise_len = $urandom_range(1, 3);
        for (int k = 0; k < noise_len; k++) queue_byte(8'($urandom()), 1'b0);
      end
      wait_idle();
    end

    // Close any record left open so its end is checked too.
    queue_byte(8'($urandom()), 1'b1);
    wait_idle();

    $display("covered %0d bytes and %0d result beats over %0d records in both modes",
             bytes_taken, runs_checked, records_done);
    $display("%0d records hit the pixel limit, %0d ended inside a tag, %0d cycles full",
             limit_records, trunc_records, full_cycles);
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("lightmap_run_length_decoder_top_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", errors, expected_runs.size());
      $display("lightmap_run_length_decoder_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d bytes waiting and %0d results owed",
             byte_backlog.size(), expected_runs.size());
    $display("lightmap_run_length_decoder_top_tb: done, errors");
    $finish;
  end

endmodule
